// ===== rtl/core/ili_pkg.sv =====
package ili_pkg;

    localparam int MAX_SEGMENTS = 16;
    localparam int VALUE_WIDTH  = 32;

    // pointer/address width and count width (count must hold MAX_SEGMENTS itself)
    localparam int IDX_W   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W   = $clog2(MAX_SEGMENTS + 1);
    localparam int ENTRY_W = 2 * VALUE_WIDTH + 2;

    typedef logic [VALUE_WIDTH-1:0] t_bound;
    typedef logic [CNT_W-1:0]       t_count;
    typedef logic [IDX_W-1:0]       t_index;

    typedef enum logic [1:0] {
        ACT_LOAD_FIRST  = 2'd0,
        ACT_LOAD_SECOND = 2'd1,
        ACT_INTERSECT   = 2'd2
    } t_action;

    // one stored interval
    typedef struct packed {
        t_bound hi;
        t_bound lo;
        logic   hc;
        logic   lc;
    } t_entry;

    // evaluation of one walk step
    typedef struct packed {
        t_bound lo;
        t_bound hi;
        logic   lc;
        logic   hc;
        logic   piece;      // non-empty piece found at this step
        logic   adv_first;  // advance the first-list pointer, else the second
    } t_step;

endpackage

// ===== rtl/core/ili_ram.sv =====
module ili_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/core/ili_step.sv =====
module ili_step (
    input  ili_pkg::t_entry i_first,
    input  ili_pkg::t_entry i_second,
    output ili_pkg::t_step  o_step
);

    import ili_pkg::*;

    logic skip;
    logic empty;

    always_comb begin
        // second interval ends before first starts: no overlap, just advance
        skip = $signed(i_second.hi) < $signed(i_first.lo);

        o_step.adv_first = ($signed(i_first.hi) < $signed(i_second.hi)) ||
                           ((i_first.hi == i_second.hi) && !i_first.hc && i_second.hc);

        // lower end: larger bound, closed on a tie only if both closed
        if ($signed(i_first.lo) > $signed(i_second.lo)) begin
            o_step.lo = i_first.lo;
            o_step.lc = i_first.lc;
        end else if (i_first.lo == i_second.lo) begin
            o_step.lo = i_first.lo;
            o_step.lc = i_first.lc & i_second.lc;
        end else begin
            o_step.lo = i_second.lo;
            o_step.lc = i_second.lc;
        end

        // upper end: smaller bound, closed on a tie only if both closed
        if ($signed(i_first.hi) < $signed(i_second.hi)) begin
            o_step.hi = i_first.hi;
            o_step.hc = i_first.hc;
        end else if (i_first.hi == i_second.hi) begin
            o_step.hi = i_first.hi;
            o_step.hc = i_first.hc & i_second.hc;
        end else begin
            o_step.hi = i_second.hi;
            o_step.hc = i_second.hc;
        end

        if (o_step.lo == o_step.hi) begin
            empty = !(o_step.lc && o_step.hc);
        end else begin
            empty = $signed(o_step.lo) > $signed(o_step.hi);
        end

        o_step.piece = !skip && !empty;
    end

endmodule

// ===== rtl/core/interval_list_intersect_top.sv =====
// Channel   Direction  Handshake            Payload
// request   in         start && !busy       i_action, i_low_value, i_high_value,
//                                           i_low_closed, i_high_closed
// result    out        o_strobe (1 cycle)   o_out_low, o_out_high, o_out_low_closed,
//                                           o_out_high_closed, o_empty_result,
//                                           o_load_dropped, o_last
//
// A load request leaves busy low, so loads may come every cycle.
// An intersect request holds busy through the walk and the finish state; the number of walk
// steps is at most first_count + second_count - 1, one step per cycle, set by the
// registered reads of the two list memories feeding the step compare.
// Reset (synchronous, active low) clears counts, drop flag and control; list
// memories are not cleared and need no clearing pass.
// The receiver cannot stall: each result shows for exactly one cycle.
module interval_list_intersect_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_action,
    input  logic signed [ili_pkg::VALUE_WIDTH-1:0] i_low_value,
    input  logic signed [ili_pkg::VALUE_WIDTH-1:0] i_high_value,
    input  logic                                i_low_closed,
    input  logic                                i_high_closed,
    output logic                                o_strobe,
    output logic signed [ili_pkg::VALUE_WIDTH-1:0] o_out_low,
    output logic signed [ili_pkg::VALUE_WIDTH-1:0] o_out_high,
    output logic                                o_out_low_closed,
    output logic                                o_out_high_closed,
    output logic                                o_empty_result,
    output logic                                o_load_dropped,
    output logic                                o_last
);

    import ili_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FINISH
    } t_state;

    t_state r_state;

    // list fill counts, walk pointers, drop flag
    t_count r_cnt_a;
    t_count r_cnt_b;
    t_count r_i;
    t_count r_j;
    logic   r_dropped;

    // pending piece: held back until the next piece is found so the final one can carry last
    logic   r_pend_valid;
    t_bound r_pend_lo;
    t_bound r_pend_hi;
    logic   r_pend_lc;
    logic   r_pend_hc;

    logic   accept;
    logic   load_a;
    logic   load_b;
    logic   run;
    logic   full_a;
    logic   full_b;
    t_entry wr_entry;
    t_entry rd_first;
    t_entry rd_second;
    t_step  step;
    t_count n_i;
    t_count n_j;
    logic   walk_done;
    t_index raddr_a;
    t_index raddr_b;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign load_a = accept && (i_action == ACT_LOAD_FIRST);
    assign load_b = accept && (i_action == ACT_LOAD_SECOND);
    assign run    = accept && (i_action == ACT_INTERSECT);
    assign full_a = (r_cnt_a == t_count'(MAX_SEGMENTS));
    assign full_b = (r_cnt_b == t_count'(MAX_SEGMENTS));

    always_comb begin
        wr_entry.lo = i_low_value;
        wr_entry.hi = i_high_value;
        wr_entry.lc = i_low_closed;
        wr_entry.hc = i_high_closed;
    end

    // evaluate the current pair of intervals
    ili_step u_step (
        .i_first  (rd_first),
        .i_second (rd_second),
        .o_step   (step)
    );

    // advance one pointer; feed the new pointers straight to the read ports
    always_comb begin
        n_i       = r_i + t_count'(step.adv_first);
        n_j       = r_j + t_count'(!step.adv_first);
        walk_done = (n_i >= r_cnt_a) || (n_j >= r_cnt_b);
        if (r_state == S_WALK) begin
            raddr_a = n_i[IDX_W-1:0];
            raddr_b = n_j[IDX_W-1:0];
        end else begin
            raddr_a = '0;
            raddr_b = '0;
        end
    end

    ili_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_SEGMENTS)
    ) u_first_mem (
        .i_clk   (i_clk),
        .i_we    (load_a && !full_a),
        .i_waddr (r_cnt_a[IDX_W-1:0]),
        .i_wdata (wr_entry),
        .i_raddr (raddr_a),
        .o_rdata (rd_first)
    );

    ili_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_SEGMENTS)
    ) u_second_mem (
        .i_clk   (i_clk),
        .i_we    (load_b && !full_b),
        .i_waddr (r_cnt_b[IDX_W-1:0]),
        .i_wdata (wr_entry),
        .i_raddr (raddr_b),
        .o_rdata (rd_second)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt_a      <= '0;
            r_cnt_b      <= '0;
            r_i          <= '0;
            r_j          <= '0;
            r_dropped    <= 1'b0;
            r_pend_valid <= 1'b0;
            o_strobe     <= 1'b0;
            o_last       <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    o_strobe <= 1'b0;
                    o_last   <= 1'b0;
                    // store loads at the fill count; drop and flag when full
                    if (load_a) begin
                        if (full_a) begin
                            r_dropped <= 1'b1;
                        end else begin
                            r_cnt_a <= r_cnt_a + t_count'(1);
                        end
                    end
                    if (load_b) begin
                        if (full_b) begin
                            r_dropped <= 1'b1;
                        end else begin
                            r_cnt_b <= r_cnt_b + t_count'(1);
                        end
                    end
                    if (run) begin
                        r_i          <= '0;
                        r_j          <= '0;
                        r_pend_valid <= 1'b0;
                        // entry 0 of both lists is read this cycle
                        if ((r_cnt_a == '0) || (r_cnt_b == '0)) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_state <= S_WALK;
                        end
                    end
                end
                S_WALK: begin
                    o_strobe <= step.piece && r_pend_valid;
                    o_last   <= 1'b0;
                    if (step.piece) begin
                        // release the previous piece, hold the new one
                        if (r_pend_valid) begin
                            o_out_low         <= r_pend_lo;
                            o_out_high        <= r_pend_hi;
                            o_out_low_closed  <= r_pend_lc;
                            o_out_high_closed <= r_pend_hc;
                            o_empty_result    <= 1'b0;
                            o_load_dropped    <= r_dropped;
                        end
                        r_pend_valid <= 1'b1;
                        r_pend_lo    <= step.lo;
                        r_pend_hi    <= step.hi;
                        r_pend_lc    <= step.lc;
                        r_pend_hc    <= step.hc;
                    end
                    r_i <= n_i;
                    r_j <= n_j;
                    if (walk_done) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    // final result: the held piece, or the empty marker
                    o_strobe       <= 1'b1;
                    o_last         <= 1'b1;
                    o_load_dropped <= r_dropped;
                    if (r_pend_valid) begin
                        o_out_low         <= r_pend_lo;
                        o_out_high        <= r_pend_hi;
                        o_out_low_closed  <= r_pend_lc;
                        o_out_high_closed <= r_pend_hc;
                        o_empty_result    <= 1'b0;
                    end else begin
                        o_out_low         <= '0;
                        o_out_high        <= '0;
                        o_out_low_closed  <= 1'b0;
                        o_out_high_closed <= 1'b0;
                        o_empty_result    <= 1'b1;
                    end
                    // clear both lists and the drop flag
                    r_cnt_a      <= '0;
                    r_cnt_b      <= '0;
                    r_dropped    <= 1'b0;
                    r_pend_valid <= 1'b0;
                    r_state      <= S_IDLE;
                end
                default: begin
                    o_strobe <= 1'b0;
                    o_last   <= 1'b0;
                    r_state  <= S_IDLE;
                end
            endcase
        end
    end

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |-> !busy && (r_cnt_a == '0) && (r_cnt_b == '0))
        else $error("lists not cleared after final result");

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_i < r_cnt_a) && (r_j < r_cnt_b))
        else $error("walk pointer beyond list count");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_empty_result |-> o_last)
        else $error("empty marker not on final result");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_a <= t_count'(MAX_SEGMENTS)) && (r_cnt_b <= t_count'(MAX_SEGMENTS)))
        else $error("list count above capacity");

    a_no_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) && !run |=> !o_strobe)
        else $error("result without a running request");

endmodule
